[src/sprq_pkg.sv]
// Package for the sorted priority ring queue: field widths, codes, entry and result types.
package sprq_pkg;

	// Default number of entries held by the queue.
	localparam int DEFAULT_CAPACITY = 16;

	// Field widths of a transaction.
	localparam int PRIO_W    = 8;
	localparam int PAYLOAD_W = 32;
	localparam int OCC_W     = 5;
	localparam int STATUS_W  = 2;

	// Operation codes.
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// Status codes reported with every result.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEQ,
		ST_SHIFT,
		ST_PLACE,
		ST_RESP
	} state_t;

	// One stored entry.
	typedef struct packed {
		logic [PRIO_W-1:0]    prio;
		logic [PAYLOAD_W-1:0] payload;
	} entry_t;

	// One result as handed from the controller to the output register.
	typedef struct packed {
		status_t              status;
		logic [PRIO_W-1:0]    prio;
		logic [PAYLOAD_W-1:0] payload;
		logic [OCC_W-1:0]     occupancy;
		logic                 is_empty;
		logic                 is_full;
	} result_t;

endpackage

[src/sprq_if.sv]
// Channel interfaces of the sorted priority ring queue: request and result.
interface sprq_in_if;
	import sprq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [PRIO_W-1:0]    in_priority;
	logic [PAYLOAD_W-1:0] in_payload;

	modport source (output valid, output op, output in_priority, output in_payload,
		input ready);
	modport sink (input valid, input op, input in_priority, input in_payload,
		output ready);
endinterface

interface sprq_out_if;
	import sprq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [PRIO_W-1:0]    out_priority;
	logic [PAYLOAD_W-1:0] out_payload;
	logic [OCC_W-1:0]     occupancy;
	logic                 is_empty;
	logic                 is_full;

	modport source (output valid, output status, output out_priority, output out_payload,
		output occupancy, output is_empty, output is_full, input ready);
	modport sink (input valid, input status, input out_priority, input out_payload,
		input occupancy, input is_empty, input is_full, output ready);
endinterface

[src/sprq_mem.sv]
// Entry store: one write port and one registered read port.
module sprq_mem #(
	parameter int DEPTH = sprq_pkg::DEFAULT_CAPACITY
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  sprq_pkg::entry_t             wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(DEPTH)-1:0]     rd_addr,
	output sprq_pkg::entry_t             rd_data
);
	import sprq_pkg::*;

	entry_t mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[src/sprq_ctrl.sv]
// Queue controller: head and count registers, sorted insert sequencer and dequeue.
module sprq_ctrl #(
	parameter int CAPACITY = sprq_pkg::DEFAULT_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sprq_in_if.sink                       in_ch,
	output logic                          res_valid,
	input  logic                          res_ready,
	output sprq_pkg::result_t             res,
	output logic                          wr_en,
	output logic [$clog2(CAPACITY)-1:0]   wr_addr,
	output sprq_pkg::entry_t              wr_data,
	output logic                          rd_en,
	output logic [$clog2(CAPACITY)-1:0]   rd_addr,
	input  sprq_pkg::entry_t              rd_data
);
	import sprq_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [IDX_W:0]   CAP_EXT  = (IDX_W + 1)'(CAPACITY);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

	state_t               state_q, state_d;
	logic [IDX_W-1:0]     head_q;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [CNT_W-1:0]     pos_q;
	logic [PRIO_W-1:0]    prio_q;
	logic [PAYLOAD_W-1:0] payload_q;
	result_t              res_q, res_d;
	logic                 res_ld;
	logic                 head_adv;
	logic                 pos_ld;
	logic                 pos_dec;
	logic                 in_fire;
	logic [IDX_W-1:0]     wr_off;
	logic [IDX_W-1:0]     rd_off;
	logic [CNT_W-1:0]     pos_m1;
	logic [CNT_W-1:0]     pos_m2;
	logic [CNT_W-1:0]     cnt_m1;

	// Slot of the entry that lies a given distance behind the head.
	function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] head,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, head} + {1'b0, off};
		if (sum >= CAP_EXT) begin
			sum = sum - CAP_EXT;
		end
		return sum[IDX_W-1:0];
	endfunction

	assign in_fire = in_ch.valid && in_ch.ready;
	assign pos_m1  = pos_q - CNT_W'(1);
	assign pos_m2  = pos_q - CNT_W'(2);
	assign cnt_m1  = count_q - CNT_W'(1);
	assign wr_addr = ring_slot(head_q, wr_off);
	assign rd_addr = ring_slot(head_q, rd_off);
	assign res_valid = (state_q == ST_RESP);
	assign res = res_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory accesses and result assembly.
	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		wr_en       = 1'b0;
		wr_off      = '0;
		wr_data     = '{prio: prio_q, payload: payload_q};
		rd_en       = 1'b0;
		rd_off      = '0;
		res_ld      = 1'b0;
		head_adv    = 1'b0;
		pos_ld      = 1'b0;
		pos_dec     = 1'b0;
		count_d     = count_q;
		res_d       = '{status: STATUS_OK, prio: '0, payload: '0, occupancy: '0,
			is_empty: 1'b0, is_full: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					if (in_ch.op == OP_ENQ) begin
						if (count_q == CNT_FULL) begin
							res_d.status = STATUS_FULL;
							res_ld       = 1'b1;
							state_d      = ST_RESP;
						end else if (count_q == '0) begin
							// First entry goes straight to the head slot.
							wr_en   = 1'b1;
							wr_data = '{prio: in_ch.in_priority, payload: in_ch.in_payload};
							count_d = count_q + CNT_W'(1);
							res_ld  = 1'b1;
							state_d = ST_RESP;
						end else begin
							rd_en   = 1'b1;
							rd_off  = cnt_m1[IDX_W-1:0];
							pos_ld  = 1'b1;
							state_d = ST_SHIFT;
						end
					end else begin
						if (count_q == '0) begin
							res_d.status = STATUS_EMPTY;
							res_ld       = 1'b1;
							state_d      = ST_RESP;
						end else begin
							rd_en   = 1'b1;
							state_d = ST_DEQ;
						end
					end
				end
			end
			ST_DEQ: begin
				res_d.prio    = rd_data.prio;
				res_d.payload = rd_data.payload;
				head_adv      = 1'b1;
				count_d       = cnt_m1;
				res_ld        = 1'b1;
				state_d       = ST_RESP;
			end
			ST_SHIFT: begin
				wr_en  = 1'b1;
				wr_off = pos_q[IDX_W-1:0];
				if (rd_data.prio > prio_q) begin
					// Move the larger entry one slot toward the tail, fetch the next one.
					wr_data = rd_data;
					pos_dec = 1'b1;
					if (pos_q == CNT_W'(1)) begin
						state_d = ST_PLACE;
					end else begin
						rd_en  = 1'b1;
						rd_off = pos_m2[IDX_W-1:0];
					end
				end else begin
					count_d = count_q + CNT_W'(1);
					res_ld  = 1'b1;
					state_d = ST_RESP;
				end
			end
			ST_PLACE: begin
				wr_en   = 1'b1;
				wr_off  = pos_q[IDX_W-1:0];
				count_d = count_q + CNT_W'(1);
				res_ld  = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res_d.occupancy = OCC_W'(count_d);
		res_d.is_empty  = (count_d == '0);
		res_d.is_full   = (count_d == CNT_FULL);
	end

	// Head pointer and occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (head_adv) begin
				head_q <= (head_q == IDX_LAST) ? '0 : head_q + IDX_W'(1);
			end
		end
	end

	// Insert position, captured transaction and pending result.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			prio_q    <= in_ch.in_priority;
			payload_q <= in_ch.in_payload;
		end
		if (pos_ld) begin
			pos_q <= count_q;
		end else if (pos_dec) begin
			pos_q <= pos_m1;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	// The count never goes beyond the capacity.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_FULL)
		else $error("entry count exceeds capacity");

	// While shifting there is always an entry in front of the insert position.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (pos_q != '0))
		else $error("shift step with insert position at the head");

	// The prefetch of the next entry never touches the slot being written.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write collide during shift");

	// An accepted transaction always leaves the idle state.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != ST_IDLE))
		else $error("accepted transaction not processed");

endmodule

[src/sorted_priority_ring_queue_top.sv]
// Top level of the sorted priority ring queue: controller, entry store and result register.
//
// Requests arrive on in_ch (valid/ready): op selects enqueue or dequeue of the head,
// in_priority and in_payload describe a new entry. Every request produces exactly one
// result transaction on out_ch with a status, the dequeued entry (zero otherwise), the
// occupancy after the operation and the empty and full flags.
// Entries are held sorted by ascending priority, equal priorities in arrival order.
// One request is processed at a time. A dequeue reads the head entry and passes it on as
// its result; a rejected request goes straight to its result. An enqueue walks from the
// tail toward the head, moving one larger entry per cycle through the single read and
// write port of the entry store, then writes the new entry into the freed slot; an
// enqueue into an empty queue writes the head slot directly. The result is presented on
// out_ch through the output register.
// A new request is taken as soon as the previous result has entered the output register,
// so a waiting result does not hold up the next request; if the receiver stalls with a
// result still in the output register, the finished result waits inside the controller
// and no further request is accepted.
// Reset empties the queue and clears all handshake state; the entry store needs no
// clearing pass, as only slots that have been written are ever read.
module sorted_priority_ring_queue_top #(
	parameter int CAPACITY = sprq_pkg::DEFAULT_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	sprq_in_if.sink     in_ch,
	sprq_out_if.source  out_ch
);
	import sprq_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);

	logic              res_valid;
	logic              res_ready;
	result_t           res;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	entry_t            rd_data;
	logic              out_valid_q;
	result_t           out_q;

	sprq_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	sprq_mem #(
		.DEPTH(CAPACITY)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Output register: takes a result when empty or when the current one leaves.
	assign res_ready = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = out_q.status;
	assign out_ch.out_priority = out_q.prio;
	assign out_ch.out_payload  = out_q.payload;
	assign out_ch.occupancy    = out_q.occupancy;
	assign out_ch.is_empty     = out_q.is_empty;
	assign out_ch.is_full      = out_q.is_full;

endmodule
